// ----- src/gba_pkg.sv -----
package gba_pkg;

  localparam int unsigned BUDGET_W = 43;
  localparam int unsigned SUM_W    = 44;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned BITS_W   = 6;
  localparam int unsigned DATA_W   = 32;

  localparam logic [DATA_W-1:0] K32 = 32'd2752;
  localparam logic [DATA_W-1:0] K8  = 32'd4755673;
  localparam logic [DATA_W-1:0] K4  = 32'd229064922;
  localparam logic [DATA_W-1:0] K2  = 32'd3817748708;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_MUL,
    ST_LOAD_DIV,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_END,
    ST_SHRINK_RD,
    ST_SHRINK_APPLY,
    ST_SHRINK_MUL,
    ST_SHRINK_DIV,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store_in;    // write the accepted word into the stores
    logic key_rd;      // read the entry to (re)key
    logic mul_go;      // register the key product
    logic div_go;      // start the divider
    logic key_wr;      // write the divider result as the key
    logic scan_clr;    // reset scan pointer and the found flag
    logic scan_step;   // examine one entry
    logic pick;        // point the key port at the best entry
    logic shrink;      // step the read entry down one width
    logic emit_clr;    // reset emit pointer
    logic emit_rd;     // read the entry to emit
    logic emit_step;   // advance the emit pointer
    logic set_infeas;
    logic run_clr;     // clear count, sum and flag
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic over_budget;
    logic scan_done;
    logic found;
    logic emit_last;
    logic full;
    logic count_zero;
  } sts_t;

  function automatic logic can_shrink(input logic [BITS_W-1:0] b);
    return (b == 6'd2) || (b == 6'd4) || (b == 6'd8) || (b == 6'd32);
  endfunction

  function automatic logic [BITS_W-1:0] next_width(input logic [BITS_W-1:0] b);
    logic [BITS_W-1:0] r;
    case (b)
      6'd32:   r = 6'd8;
      6'd8:    r = 6'd4;
      6'd4:    r = 6'd2;
      6'd2:    r = 6'd1;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] width_const(input logic [BITS_W-1:0] b);
    logic [DATA_W-1:0] r;
    case (b)
      6'd32:   r = K32;
      6'd8:    r = K8;
      6'd4:    r = K4;
      6'd2:    r = K2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/gba_div.sv -----
module gba_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gba_pkg::KEY_W-1:0]   dividend,
  input  logic [gba_pkg::DATA_W-1:0]  divisor,
  output logic                        busy,
  output logic [gba_pkg::KEY_W-1:0]   quotient
);

  // restoring divider, one quotient bit a cycle
  logic [gba_pkg::KEY_W-1:0]  quo;
  logic [gba_pkg::DATA_W:0]   rem;
  logic [gba_pkg::DATA_W-1:0] dvs;
  logic [6:0]                 cnt;
  logic [gba_pkg::DATA_W:0]   trial;
  logic [gba_pkg::DATA_W:0]   diff;

  assign trial = {rem[gba_pkg::DATA_W-1:0], quo[gba_pkg::KEY_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'(gba_pkg::KEY_W);
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (!diff[gba_pkg::DATA_W]) begin
        rem <= diff;
        quo <= {quo[gba_pkg::KEY_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[gba_pkg::KEY_W-2:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = (dvs == '0) ? '1 : quo;

endmodule

// ----- src/gba_ctrl.sv -----
module gba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  input  gba_pkg::sts_t   sts,
  output gba_pkg::cmd_t   cmd
);

  gba_pkg::state_t state, state_next;
  logic            last_seen, last_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gba_pkg::ST_IDLE;
      last_seen <= 1'b0;
    end else begin
      state     <= state_next;
      last_seen <= last_seen_next;
    end
  end

  always_comb begin
    state_next     = state;
    last_seen_next = last_seen;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    case (state)
      gba_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          last_seen_next = in_last;
          if (!sts.full) begin
            cmd.store_in = 1'b1;
            state_next   = gba_pkg::ST_LOAD_RD;
          end else if (in_last) begin
            state_next = gba_pkg::ST_CHECK;
          end
        end
      end
      gba_pkg::ST_LOAD_RD: begin
        cmd.key_rd = 1'b1;
        state_next = gba_pkg::ST_LOAD_MUL;
      end
      gba_pkg::ST_LOAD_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = gba_pkg::ST_LOAD_DIV;
      end
      gba_pkg::ST_LOAD_DIV: begin
        cmd.div_go = 1'b1;
        state_next = gba_pkg::ST_SHRINK_DIV;
      end
      gba_pkg::ST_SHRINK_DIV: begin
        if (!sts.div_busy) begin
          cmd.key_wr = 1'b1;
          state_next = last_seen ? gba_pkg::ST_CHECK : gba_pkg::ST_IDLE;
        end
      end
      gba_pkg::ST_CHECK: begin
        cmd.scan_clr = 1'b1;
        if (sts.over_budget) begin
          state_next = gba_pkg::ST_SCAN;
        end else begin
          cmd.emit_clr = 1'b1;
          state_next   = sts.count_zero ? gba_pkg::ST_IDLE : gba_pkg::ST_EMIT_RD;
          if (sts.count_zero) begin
            cmd.run_clr = 1'b1;
          end
        end
      end
      gba_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = gba_pkg::ST_SCAN_END;
        end
      end
      gba_pkg::ST_SCAN_END: begin
        if (sts.found) begin
          cmd.pick   = 1'b1;
          state_next = gba_pkg::ST_SHRINK_RD;
        end else begin
          cmd.set_infeas = 1'b1;
          cmd.emit_clr   = 1'b1;
          state_next     = gba_pkg::ST_EMIT_RD;
        end
      end
      gba_pkg::ST_SHRINK_RD: begin
        cmd.key_rd = 1'b1;
        state_next = gba_pkg::ST_SHRINK_APPLY;
      end
      gba_pkg::ST_SHRINK_APPLY: begin
        cmd.shrink = 1'b1;
        state_next = gba_pkg::ST_SHRINK_MUL;
      end
      gba_pkg::ST_SHRINK_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = gba_pkg::ST_LOAD_DIV;
      end
      gba_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = gba_pkg::ST_EMIT;
      end
      gba_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) begin
            cmd.run_clr    = 1'b1;
            last_seen_next = 1'b0;
            state_next     = gba_pkg::ST_IDLE;
          end else begin
            state_next = gba_pkg::ST_EMIT_RD;
          end
        end
      end
      default: state_next = gba_pkg::ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == gba_pkg::ST_SCAN_END && !sts.found) |=> state == gba_pkg::ST_EMIT_RD)
    else $error("missing emit after infeasible scan");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during emit");
  assert property (@(posedge clk) disable iff (rst)
    cmd.key_wr |-> !sts.div_busy)
    else $error("key written while divider busy");

endmodule

// ----- src/gba_dp.sv -----
module gba_dp #(
  parameter int unsigned MAX_LAYERS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gba_pkg::BUDGET_W-1:0]  budget,
  input  logic [gba_pkg::BITS_W-1:0]    in_bits,
  input  logic [gba_pkg::DATA_W-1:0]    in_sens,
  input  logic [gba_pkg::DATA_W-1:0]    in_wt,
  input  gba_pkg::cmd_t                 cmd,
  output gba_pkg::sts_t                 sts,
  output logic [5:0]                    out_index,
  output logic [gba_pkg::BITS_W-1:0]    out_bits,
  output logic                          out_infeas,
  output logic                          out_last
);

  localparam int unsigned IW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned CW    = $clog2(MAX_LAYERS + 1);
  localparam int unsigned SUM_W = gba_pkg::SUM_W;
  localparam int unsigned PW    = gba_pkg::BITS_W + gba_pkg::DATA_W;

  logic [gba_pkg::BITS_W-1:0] width_mem [MAX_LAYERS];
  logic [gba_pkg::DATA_W-1:0] sens_mem  [MAX_LAYERS];
  logic [gba_pkg::DATA_W-1:0] wt_mem    [MAX_LAYERS];
  logic [gba_pkg::KEY_W-1:0]  key_mem   [MAX_LAYERS];

  logic [CW-1:0]              count;
  logic [gba_pkg::SUM_W-1:0]  wsum;
  logic                       infeas;
  logic [IW-1:0]              wptr;      // entry being keyed
  logic [IW-1:0]              scan_ptr;
  logic [IW-1:0]              emit_ptr;
  logic [IW-1:0]              wd_addr;   // single read port of the width store
  logic [IW-1:0]              best;
  logic                       found;
  logic [gba_pkg::KEY_W-1:0]  best_key;
  logic [gba_pkg::BITS_W-1:0] rd_bits;
  logic [gba_pkg::DATA_W-1:0] rd_sens;
  logic [gba_pkg::DATA_W-1:0] rd_wt;
  logic [gba_pkg::KEY_W-1:0]  product;
  logic [gba_pkg::KEY_W-1:0]  quotient;
  logic                       div_busy;
  logic [gba_pkg::BITS_W-1:0] sc_bits;
  logic [gba_pkg::KEY_W-1:0]  sc_key;
  logic                       sc_valid;
  logic [IW-1:0]              sc_idx;
  logic                       sc_last;
  logic [gba_pkg::BITS_W-1:0] nb;
  logic [gba_pkg::SUM_W-1:0]  dec;

  gba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (product),
    .divisor  (rd_wt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    if (cmd.key_rd) begin
      wd_addr = wptr;
    end else if (cmd.emit_rd) begin
      wd_addr = emit_ptr;
    end else begin
      wd_addr = scan_ptr;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.store_in) begin
      width_mem[count[IW-1:0]] <= in_bits;
      sens_mem[count[IW-1:0]]  <= in_sens;
      wt_mem[count[IW-1:0]]    <= in_wt;
    end else if (cmd.shrink) begin
      width_mem[wptr] <= nb;
    end
    if (cmd.key_wr) begin
      key_mem[wptr] <= gba_pkg::can_shrink(rd_bits) ? quotient : '0;
    end
  end

  // keyed-entry read, also used for shrink bookkeeping, the key product, emit and the scan stage
  always_ff @(posedge clk) begin
    if (cmd.key_rd) begin
      rd_bits <= width_mem[wd_addr];
      rd_sens <= sens_mem[wptr];
      rd_wt   <= wt_mem[wptr];
    end else if (cmd.shrink) begin
      rd_bits <= nb;
    end
    if (cmd.emit_rd) begin
      out_bits <= width_mem[wd_addr];
    end
    if (cmd.mul_go) begin
      product <= rd_sens * gba_pkg::width_const(rd_bits);
    end
    sc_bits <= width_mem[wd_addr];
    sc_key  <= key_mem[scan_ptr];
    sc_idx  <= scan_ptr;
  end

  assign nb  = gba_pkg::next_width(rd_bits);
  assign dec = SUM_W'(PW'(rd_bits - nb) * PW'(rd_wt));

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wsum     <= '0;
      infeas   <= 1'b0;
      sc_valid <= 1'b0;
      sc_last  <= 1'b0;
    end else begin
      if (cmd.store_in) begin
        wptr  <= count[IW-1:0];
        count <= count + CW'(1);
        if (gba_pkg::can_shrink(in_bits)) begin
          wsum <= wsum + SUM_W'(PW'(in_bits) * PW'(in_wt));
        end
      end
      if (cmd.pick) begin
        wptr <= best;
      end
      if (cmd.shrink) begin
        wsum <= wsum - dec;
      end
      if (cmd.scan_clr) begin
        scan_ptr <= '0;
        found    <= 1'b0;
        sc_valid <= 1'b0;
        sc_last  <= 1'b0;
      end else if (cmd.scan_step) begin
        sc_valid <= 1'b1;
        sc_last  <= (CW'(scan_ptr) + CW'(1) >= count);
        if (CW'(scan_ptr) + CW'(1) < count) begin
          scan_ptr <= scan_ptr + IW'(1);
        end
        if (sc_valid && gba_pkg::can_shrink(sc_bits) && (!found || sc_key <= best_key)) begin
          best     <= sc_idx;
          best_key <= sc_key;
          found    <= 1'b1;
        end
        if (sc_last) begin
          sc_valid <= 1'b0;
        end
      end
      if (cmd.set_infeas) begin
        infeas <= 1'b1;
      end
      if (cmd.emit_clr) begin
        emit_ptr <= '0;
      end else if (cmd.emit_step) begin
        emit_ptr <= emit_ptr + IW'(1);
      end
      if (cmd.run_clr) begin
        count  <= '0;
        wsum   <= '0;
        infeas <= 1'b0;
      end
    end
  end

  always_comb begin
    sts             = '0;
    sts.div_busy    = div_busy;
    sts.over_budget = wsum > {1'b0, budget};
    sts.scan_done   = sc_valid && sc_last;
    sts.found       = found;
    sts.emit_last   = (CW'(emit_ptr) + CW'(1) >= count);
    sts.full        = (count >= CW'(MAX_LAYERS));
    sts.count_zero  = (count == '0);
  end

  assign out_index  = 6'(emit_ptr);
  assign out_infeas = infeas;
  assign out_last   = sts.emit_last;

endmodule

// ----- src/greedy_bit_allocation.sv -----
// Load: each stored layer is keyed by the divider before the next word is taken.
// Allocation: each greedy step scans all held layers, then
// rekeys the shrunk layer on the shared divider.
// Emit: each result word is read from the stores (EMIT_RD), then offered (EMIT) until the output takes it.
// Items are taken one at a time; the input stalls until the run has drained.
// Synchronous active-high rst clears the budget, layer count, running sum and flags.
module greedy_bit_allocation #(
  parameter int unsigned MAX_LAYERS = 64
) (
  input  logic         clk,
  input  logic         rst,
  // budget register
  input  logic         cfg_we,
  input  logic [42:0]  cfg_wdata,
  // input words
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [5:0]   layer_bits,
  input  logic [31:0]  sensitivity,
  input  logic [31:0]  element_weight,
  input  logic         last_layer,
  // result words
  output logic         out_valid,
  input  logic         out_stall,
  output logic [5:0]   layer_index,
  output logic [5:0]   final_bits,
  output logic         infeasible,
  output logic         last_result
);

  logic [gba_pkg::BUDGET_W-1:0] bit_budget;
  gba_pkg::cmd_t                cmd;
  gba_pkg::sts_t                sts;

  // hold the budget across runs
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_budget <= '0;
    end else if (cfg_we) begin
      bit_budget <= cfg_wdata;
    end
  end

  gba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (last_layer),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  gba_dp #(.MAX_LAYERS(MAX_LAYERS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .budget     (bit_budget),
    .in_bits    (layer_bits),
    .in_sens    (sensitivity),
    .in_wt      (element_weight),
    .cmd        (cmd),
    .sts        (sts),
    .out_index  (layer_index),
    .out_bits   (final_bits),
    .out_infeas (infeasible),
    .out_last   (last_result)
  );

endmodule
